### hdl/tplru_pkg.sv
`default_nettype none

package tplru_pkg;

    // Width of a way number on the ports (up to 32 ways).
    localparam int WAY_W = 5;

    // Request kinds carried on the input tuser bit.
    localparam logic FUNC_FIND  = 1'b0;
    localparam logic FUNC_TOUCH = 1'b1;

    // Configuration register indexes and widths.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_LOG2   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd2;

    localparam int WL_W  = 3;
    localparam int IB_W  = 4;
    localparam int OFS_W = 4;

    localparam logic [WL_W-1:0]  RST_WAYS_LOG2   = 3'd2;
    localparam logic [IB_W-1:0]  RST_INDEX_BITS  = 4'd8;
    localparam logic [OFS_W-1:0] RST_OFFSET_BITS = 4'd4;

    // Output tdata is the victim way padded to a whole byte.
    localparam int OUT_TDATA_W = 8;

endpackage

`default_nettype wire

### hdl/tree_plru_replacement.sv
`default_nettype none

// Tree pseudo-LRU replacement for a set-associative cache. Each set keeps a binary tree of
// bits in preorder (root is bit 0, the left child of node i is i+1, the right child is i+n
// where n is the number of ways under each child). A find request (tuser = 0) walks the
// tree from the root, going right where a bit is 0 and left where it is 1, and returns the
// reached way on the master side. A touch request (tuser = 1) rewrites the bits on the path
// toward the given way and returns nothing. The set is (address >> offset_bits) masked to
// index_bits. The block takes one request every cycle while no find is held up by the
// result side. The tree store is read at the accepting edge, and the walk sits between
// that read register and the result register. A touch followed at once by a request to
// the same set is served by forwarding the new tree bits. After reset the tree store is
// swept to zero, one set per cycle, holding s_axis_tready low; configuration writes are
// taken at any time but must only be issued while the block is idle.
module tree_plru_replacement #(
    parameter int MAX_INDEX_BITS = 8,
    parameter int MAX_WAYS       = 32,
    parameter int ADDRESS_BITS   = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,

    // Configuration write port.
    input  wire logic                                i_cfg_we,
    input  wire logic [tplru_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [tplru_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,

    // Request channel.
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // tdata, lowest bit up: address, way, zero fill.
    input  wire logic [((ADDRESS_BITS + tplru_pkg::WAY_W + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // tuser: func (0 find, 1 touch).
    input  wire logic [0:0]                          s_axis_tuser,

    // Result channel.
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // tdata, lowest bit up: victim_way, zero fill.
    output logic [tplru_pkg::OUT_TDATA_W-1:0]        m_axis_tdata
);
    import tplru_pkg::*;

    // Largest usable tree depth: floor(log2(MAX_WAYS)).
    localparam int MAX_LOG   = $clog2(MAX_WAYS + 1) - 1;
    // One bit per node; the top bit is a spare that stays zero.
    localparam int TREE_W    = 1 << MAX_LOG;
    localparam int SET_W     = MAX_INDEX_BITS;
    localparam int SET_COUNT = 1 << SET_W;
    localparam int SH_W      = (ADDRESS_BITS > SET_W) ? ADDRESS_BITS : SET_W;

    // Configuration registers.
    logic [WL_W-1:0]  r_ways_log2;
    logic [IB_W-1:0]  r_index_bits;
    logic [OFS_W-1:0] r_offset_bits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ways_log2   <= RST_WAYS_LOG2;
            r_index_bits  <= RST_INDEX_BITS;
            r_offset_bits <= RST_OFFSET_BITS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WAYS_LOG2:   r_ways_log2   <= i_cfg_wdata[WL_W-1:0];
                CFG_INDEX_BITS:  r_index_bits  <= i_cfg_wdata[IB_W-1:0];
                CFG_OFFSET_BITS: r_offset_bits <= i_cfg_wdata[OFS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Effective tree depth and index width, both saturated to what the store holds.
    logic [WL_W-1:0] wl_eff;
    logic [IB_W-1:0] ib_eff;

    assign wl_eff = (32'(r_ways_log2) > MAX_LOG) ? WL_W'(MAX_LOG) : r_ways_log2;
    assign ib_eff = (32'(r_index_bits) > SET_W) ? IB_W'(SET_W) : r_index_bits;

    // Request fields.
    logic                    in_func;
    logic [ADDRESS_BITS-1:0] in_addr;
    logic [WAY_W-1:0]        in_way;
    logic [SH_W-1:0]         in_shifted;
    logic [SH_W-1:0]         in_mask;
    logic [SET_W-1:0]        in_set;
    logic [MAX_LOG-1:0]      in_way_m;

    assign in_func    = s_axis_tuser[0];
    assign in_addr    = s_axis_tdata[ADDRESS_BITS-1:0];
    assign in_way     = s_axis_tdata[ADDRESS_BITS +: WAY_W];
    assign in_shifted = SH_W'(in_addr) >> r_offset_bits;
    assign in_mask    = ~({SH_W{1'b1}} << ib_eff);
    assign in_set     = SET_W'(in_shifted & in_mask);
    // Touch wraps the way to its low ways_log2 bits.
    assign in_way_m   = in_way[MAX_LOG-1:0] & ~({MAX_LOG{1'b1}} << wl_eff);

    // Clearing sweep after reset.
    logic             r_clearing;
    logic [SET_W-1:0] r_clr_idx;

    // Walk stage registers.
    logic               r_s1_valid;
    logic               r_s1_func;
    logic [SET_W-1:0]   r_s1_set;
    logic [MAX_LOG-1:0] r_s1_way;
    logic [TREE_W-1:0]  r_rd_data;
    logic               r_fwd_hit;
    logic [TREE_W-1:0]  r_fwd_data;

    // Result register.
    logic             r_out_valid;
    logic [WAY_W-1:0] r_out_way;

    logic in_accept;
    logic s1_fire;
    logic mem_we;

    assign s1_fire       = r_s1_valid && (r_s1_func == FUNC_TOUCH || !r_out_valid
                                          || m_axis_tready);
    assign s_axis_tready = !r_clearing && (!r_s1_valid || s1_fire);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Tree walk over the current bits of the set.
    logic [TREE_W-1:0]  cur_bits;
    logic [TREE_W-1:0]  new_bits;
    logic [MAX_LOG-1:0] victim;

    assign cur_bits = r_fwd_hit ? r_fwd_data : r_rd_data;

    always_comb begin
        logic [MAX_LOG-1:0] node_f;
        logic [MAX_LOG-1:0] node_t;
        logic [MAX_LOG-1:0] n;
        new_bits = cur_bits;
        victim   = '0;
        node_f   = '0;
        node_t   = '0;
        n        = '0;
        for (int k = 0; k < MAX_LOG; k++) begin
            if (k < int'(wl_eff)) begin
                n = MAX_LOG'(1) << (int'(wl_eff) - 1 - k);
                // Find: go right on a clear bit, left on a set bit.
                if (!cur_bits[node_f]) begin
                    victim = victim | n;
                    node_f = node_f + n;
                end else begin
                    node_f = node_f + MAX_LOG'(1);
                end
                // Touch: mark the path toward the accessed way.
                if ((r_s1_way & n) != '0) begin
                    new_bits[node_t] = 1'b1;
                    node_t = node_t + n;
                end else begin
                    new_bits[node_t] = 1'b0;
                    node_t = node_t + MAX_LOG'(1);
                end
            end
        end
    end

    // Tree store.
    logic [TREE_W-1:0] mem [SET_COUNT];
    logic [SET_W-1:0]  mem_wa;
    logic [TREE_W-1:0] mem_wd;

    assign mem_we = r_clearing || (s1_fire && r_s1_func == FUNC_TOUCH);
    assign mem_wa = r_clearing ? r_clr_idx : r_s1_set;
    assign mem_wd = r_clearing ? '0 : new_bits;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (in_accept) begin
            r_rd_data <= mem[in_set];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_idx   <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_idx <= r_clr_idx + SET_W'(1);
                if (r_clr_idx == {SET_W{1'b1}}) begin
                    r_clearing <= 1'b0;
                end
            end
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire && r_s1_func == FUNC_FIND) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_func  <= in_func;
            r_s1_set   <= in_set;
            r_s1_way   <= in_way_m;
            // The store is read before this edge's write lands, so a touch to the
            // same set leaving the walk now is passed along directly.
            r_fwd_hit  <= s1_fire && r_s1_func == FUNC_TOUCH && r_s1_set == in_set;
            r_fwd_data <= new_bits;
        end
        if (s1_fire && r_s1_func == FUNC_FIND) begin
            r_out_way <= WAY_W'(victim);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out_way);

    // The sweep owns the store port; no request may enter while it runs.
    a_no_accept_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !s_axis_tready)
        else $error("request accepted during tree store clearing");

    // A find leaving the walk always shows up as a result on the next cycle.
    a_find_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_s1_func == FUNC_FIND) |=> m_axis_tvalid)
        else $error("find request lost its result");

    // A victim never lies beyond the configured number of ways.
    a_victim_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((r_out_way >> wl_eff) == '0))
        else $error("victim way outside the associativity");

    // The walk stage cannot hold an item while the store is being swept.
    a_walk_idle_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !r_s1_valid)
        else $error("walk stage busy during clearing");

endmodule

`default_nettype wire

### dv/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tplru_pkg::*;

    // Block parameters, kept at the values the block is built with.
    localparam int MAX_INDEX_BITS = 8;
    localparam int MAX_WAYS       = 32;
    localparam int ADDRESS_BITS   = 16;
    localparam int MAX_WAYS_LOG2  = 5;
    localparam int SET_COUNT      = 1 << MAX_INDEX_BITS;
    localparam int IN_TDATA_W     = ((ADDRESS_BITS + WAY_W + 7) / 8) * 8;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 10;
    // Cycles to let pass after the last result before a register write or the end,
    // since a touch request leaves no result to wait for.
    localparam int SETTLE_CYCLES  = 8;
    // The receiver's long hold-off, and the number of cycles without any request
    // or result moving that counts as a hang. The limit covers the clearing sweep
    // after reset and the long hold-off several times over.
    localparam int HOLD_CYCLES    = 200;
    localparam int HANG_LIMIT     = 2000;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_PHASES  = 12;
    localparam int PICKS_PER_PHASE = 52;

    // Clock, reset and all block inputs start at known values.
    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = CFG_WAYS_LOG2;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // tdata, lowest bit up: address, way, zero fill.
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    // tuser: func (0 find, 1 touch).
    logic [0:0]             s_axis_tuser = FUNC_FIND;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // tdata, lowest bit up: victim_way, zero fill.
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    always #CLK_HALF i_clk = ~i_clk;

    tree_plru_replacement #(
        .MAX_INDEX_BITS(MAX_INDEX_BITS),
        .MAX_WAYS      (MAX_WAYS),
        .ADDRESS_BITS  (ADDRESS_BITS)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // Our own copy of the replacement state and the configuration registers.
    logic [30:0]      tree_mem [SET_COUNT];
    logic [WL_W-1:0]  cfg_ways_log2 = RST_WAYS_LOG2;
    logic [IB_W-1:0]  cfg_index_bits = RST_INDEX_BITS;
    logic [OFS_W-1:0] cfg_offset_bits = RST_OFFSET_BITS;

    // Victim ways still to come out of the block, oldest first.
    logic [WAY_W-1:0] victim_q [$];
    logic [WAY_W-1:0] last_victim = '0;

    int unsigned fail_count = 0;
    int unsigned burst_left = 0;
    bit          sender_gaps = 1'b1;
    bit          hold_request = 1'b0;
    bit          hold_active = 1'b0;

    initial begin
        for (int s = 0; s < SET_COUNT; s++) tree_mem[s] = '0;
    end

    // Applies one accepted request to our copy of the tree store. A find request
    // walks the complemented bits from the root and queues the way it reaches; a
    // touch request points every bit on the path away from the accessed way.
    task automatic apply_plru_request(input logic func, input logic [15:0] addr,
                                      input logic [WAY_W-1:0] way);
        int unsigned ib, wl, set_idx, node, n, victim, w;
        logic [30:0] bits;
        ib = (cfg_index_bits > MAX_INDEX_BITS) ? MAX_INDEX_BITS : cfg_index_bits;
        wl = (cfg_ways_log2 > MAX_WAYS_LOG2) ? MAX_WAYS_LOG2 : cfg_ways_log2;
        set_idx = ((32'(addr) >> cfg_offset_bits) & ((1 << ib) - 1)) & (SET_COUNT - 1);
        bits = tree_mem[set_idx];
        node = 0;
        if (func == FUNC_FIND) begin
            victim = 0;
            for (n = (1 << wl) >> 1; n > 0; n = n >> 1) begin
                if (bits[node] == 1'b0) begin
                    victim += n;
                    node += n;
                end else begin
                    node += 1;
                end
            end
            last_victim = WAY_W'(victim);
            victim_q.push_back(WAY_W'(victim));
        end else begin
            // A way beyond the configured count wraps to its low bits.
            w = way & ((1 << wl) - 1);
            for (n = (1 << wl) >> 1; n > 0; n = n >> 1) begin
                if (w >= n) begin
                    bits[node] = 1'b1;
                    node += n;
                    w -= n;
                end else begin
                    bits[node] = 1'b0;
                    node += 1;
                end
            end
            tree_mem[set_idx] = bits;
        end
    endtask

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) $display("%s", msg);
    endtask

    // Offers one request from a falling edge and returns at the falling edge after
    // it was accepted. With gaps on, the sender works in bursts and valid drops for a
    // random gap when a burst runs out; else it stays high from one request to the next.
    task automatic send_request(input logic func, input logic [15:0] addr,
                                input logic [WAY_W-1:0] way);
        if (sender_gaps && burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0) burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - ADDRESS_BITS - WAY_W){1'b0}}, way, addr};
        s_axis_tuser  <= func;
        do @(posedge i_clk); while (!s_axis_tready);
        apply_plru_request(func, addr, way);
        @(negedge i_clk);
    endtask

    // Stops offering requests and waits until every expected result is out, then
    // lets a trailing touch request settle.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (victim_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Writes all three registers on consecutive cycles; only called while idle.
    task automatic set_config(input logic [CFG_DATA_W-1:0] wl, input logic [CFG_DATA_W-1:0] ib,
                              input logic [CFG_DATA_W-1:0] ofs);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_WAYS_LOG2;
        i_cfg_wdata <= wl;
        @(negedge i_clk);
        i_cfg_index <= CFG_INDEX_BITS;
        i_cfg_wdata <= ib;
        @(negedge i_clk);
        i_cfg_index <= CFG_OFFSET_BITS;
        i_cfg_wdata <= ofs;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_ways_log2   = wl[WL_W-1:0];
        cfg_index_bits  = ib;
        cfg_offset_bits = ofs;
    endtask

    // With the reset configuration of four ways, every set starts with victim 3.
    // The touch of way 29 checks that an out-of-range way wraps to way 1.
    task automatic test_reset_defaults();
        send_request(FUNC_FIND,  16'h0000, 5'd0);
        send_request(FUNC_FIND,  16'hFFFF, 5'd0);
        send_request(FUNC_TOUCH, 16'hFFFF, 5'd3);
        send_request(FUNC_FIND,  16'hFFFF, 5'd0);
        send_request(FUNC_TOUCH, 16'h0010, 5'd29);
        send_request(FUNC_FIND,  16'h0010, 5'd31);
        wait_idle();
    endtask

    // The widest tree, saturation of both the way count and the index width, the
    // largest offset, and the single-way case where find always returns way 0.
    task automatic test_config_extremes();
        set_config(4'd5, 4'd8, 4'd0);
        send_request(FUNC_TOUCH, 16'h00AB, 5'd31);
        send_request(FUNC_FIND,  16'h00AB, 5'd0);
        send_request(FUNC_TOUCH, 16'h00AB, 5'd0);
        send_request(FUNC_FIND,  16'h00AB, 5'd0);
        send_request(FUNC_FIND,  16'h1234, 5'd0);
        wait_idle();
        set_config(4'hF, 4'hF, 4'hF);
        send_request(FUNC_TOUCH, 16'h8000, 5'd16);
        send_request(FUNC_FIND,  16'h8000, 5'd0);
        send_request(FUNC_FIND,  16'h7FFF, 5'd0);
        wait_idle();
        set_config(4'd0, 4'd0, 4'd0);
        send_request(FUNC_TOUCH, 16'h5555, 5'd31);
        send_request(FUNC_FIND,  16'h5555, 5'd0);
        send_request(FUNC_FIND,  16'hAAAA, 5'd0);
        wait_idle();
    endtask

    // Random traffic over a series of configurations, the first few at the edges.
    // Most requests land on a small pool of sets so the trees get deep history;
    // many are fill sequences that find a victim and then touch exactly that way. A touch is
    // often followed at once by another to its set, so the block forwards new tree bits.
    task automatic test_random_traffic();
        logic [15:0] pool [4];
        logic [15:0] addr;
        logic [3:0]  wl, ib, ofs;
        int unsigned pick;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin wl = 4'd5; ib = 4'd8;  ofs = 4'd0;  end
                1: begin wl = 4'd0; ib = 4'd0;  ofs = 4'd15; end
                2: begin wl = 4'd7; ib = 4'd15; ofs = 4'd4;  end
                3: begin wl = 4'd1; ib = 4'd1;  ofs = 4'd15; end
                4: begin wl = 4'd3; ib = 4'd2;  ofs = 4'd14; end
                5: begin wl = 4'd5; ib = 4'd3;  ofs = 4'd0;  end
                default: begin
                    wl  = 4'($urandom_range(0, 15));
                    ib  = 4'($urandom_range(0, 15));
                    ofs = 4'($urandom_range(0, 15));
                end
            endcase
            set_config(wl, ib, ofs);
            sender_gaps = (phase % 3) != 2;
            for (int p = 0; p < 4; p++) pool[p] = 16'($urandom);
            for (int k = 0; k < PICKS_PER_PHASE; k++) begin
                pick = $urandom_range(0, 9);
                if (pick < 8) begin
                    // Same set as a pool entry, with random bits below the offset.
                    addr = pool[$urandom_range(0, 3)] |
                           (16'($urandom) & 16'((1 << ofs) - 1));
                end else begin
                    addr = 16'($urandom);
                end
                pick = $urandom_range(0, 9);
                if (pick < 3) begin
                    send_request(FUNC_FIND, addr, 5'($urandom));
                end else if (pick < 5) begin
                    send_request(FUNC_TOUCH, addr, 5'($urandom));
                end else begin
                    send_request(FUNC_FIND, addr, 5'($urandom));
                    send_request(FUNC_TOUCH, addr, last_victim);
                end
            end
            wait_idle();
        end
        sender_gaps = 1'b1;
    endtask

    // The receiver holds off for a long stretch while requests keep coming with
    // no gaps, so the result side backs up and the block must stall its input.
    task automatic test_output_stall();
        logic [15:0] base;
        set_config(4'd4, 4'd6, 4'd3);
        sender_gaps = 1'b0;
        base = 16'($urandom);
        hold_request = 1'b1;
        while (!hold_active) @(negedge i_clk);
        for (int k = 0; k < 48; k++) begin
            if ($urandom_range(0, 2) == 0)
                send_request(FUNC_TOUCH, base ^ 16'($urandom_range(0, 1) << 3), 5'($urandom));
            else
                send_request(FUNC_FIND, base ^ 16'($urandom_range(0, 1) << 3), 5'd0);
        end
        wait_idle();
        sender_gaps = 1'b1;
    endtask

    // Result receiver: stretches of always ready, coin-flip ready, one cycle in
    // three, and mostly ready with short stalls. A long hold-off is served when
    // a test asks for it.
    initial begin : result_receiver
        int unsigned stretch, style;
        forever begin
            style   = $urandom_range(0, 3);
            stretch = $urandom_range(10, 80);
            for (int k = 0; k < stretch; k++) begin
                @(negedge i_clk);
                if (hold_request) begin
                    hold_active = 1'b1;
                    m_axis_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge i_clk);
                    hold_request = 1'b0;
                    hold_active  = 1'b0;
                end
                case (style)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= (k % 3) == 0;
                    default: m_axis_tready <= $urandom_range(0, 7) != 0;
                endcase
            end
        end
    end

    // Every result taken from the block is checked against the oldest expected
    // victim way. Sampling at the rising edge sees the values from before it.
    always @(posedge i_clk) begin : result_check
        logic [WAY_W-1:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (victim_q.size() == 0) begin
                note_failure($sformatf("unexpected result: victim_way %0d",
                                       m_axis_tdata[WAY_W-1:0]));
            end else begin
                want = victim_q.pop_front();
                if (m_axis_tdata[WAY_W-1:0] !== want)
                    note_failure($sformatf("victim_way mismatch: expected %0d, got %0d",
                                           want, m_axis_tdata[WAY_W-1:0]));
            end
        end
    end

    // Hang detection: ends the run when neither a request nor a result has moved
    // for too long.
    initial begin : hang_watch
        int unsigned quiet;
        quiet = 0;
        while (quiet < HANG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_top failed");
        $finish;
    end

    initial begin : main_sequence
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_defaults();
        test_config_extremes();
        test_random_traffic();
        test_output_stall();
        wait_idle();
        if (fail_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
